>>> hdl/utv_pkg.sv
// shared types and constants of the utf-8 text validator
package utv_pkg;

   localparam int POSITION_BITS = 16;
   localparam int OFFSET_BITS   = 16;
   localparam int LIMIT_BITS    = 16;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   localparam logic [LIMIT_BITS-1:0] SCAN_LIMIT_RESET = LIMIT_BITS'(1000);
   localparam logic [POSITION_BITS:0] MIN_FILE_LEN    = (POSITION_BITS + 1)'(8);
   localparam logic [POSITION_BITS:0] TAIL_GAP        = (POSITION_BITS + 1)'(5);

   localparam logic [7:0] CONT_LO = 8'h80;
   localparam logic [7:0] CONT_HI = 8'hBF;

   // register index of scan_limit (word address)
   localparam logic REG_SCAN_LIMIT = 1'b0;

   // one classified request travelling from front to back
   typedef struct packed {
      logic [7:0]               data_byte;
      logic                     last_byte;
      logic [POSITION_BITS-1:0] position;
      logic                     lead_ok;
      logic [1:0]               lead_count;
      logic [7:0]               lead_lo;
      logic [7:0]               lead_hi;
   } entry_type;

endpackage

>>> hdl/utv_front.sv
// front end: accepts bytes, tracks offset and classifies lead bytes
module utv_front
   import utv_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  logic [7:0] in_byte,
   input  logic       in_last,
   output logic       push_valid,
   input  logic       push_ready,
   output entry_type  push_entry
);

   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic                     accept;
   logic                     lead_ok;
   logic [1:0]               lead_count;
   logic [7:0]               lead_lo, lead_hi;

   assign in_ready   = push_ready;
   assign push_valid = in_valid;
   assign accept     = in_valid && push_ready;

   // lead byte class: continuation count and range of the second byte
   always_comb begin
      lead_ok    = 1'b1;
      lead_count = 2'd0;
      lead_lo    = CONT_LO;
      lead_hi    = CONT_HI;
      if ((in_byte >= 8'h09 && in_byte <= 8'h0D) || (in_byte >= 8'h20 && in_byte <= 8'h9F)) begin
         lead_count = 2'd0;
      end else if (in_byte >= 8'hC2 && in_byte <= 8'hDF) begin
         lead_count = 2'd1;
      end else if (in_byte == 8'hE0) begin
         lead_count = 2'd2;
         lead_lo    = 8'hA0;
      end else if ((in_byte >= 8'hE1 && in_byte <= 8'hEC) || in_byte == 8'hEE
                   || in_byte == 8'hEF) begin
         lead_count = 2'd2;
      end else if (in_byte == 8'hED) begin
         lead_count = 2'd2;
         lead_hi    = 8'h9F;
      end else if (in_byte == 8'hF0) begin
         lead_count = 2'd3;
         lead_lo    = 8'h90;
      end else if (in_byte >= 8'hF1 && in_byte <= 8'hF3) begin
         lead_count = 2'd3;
      end else if (in_byte == 8'hF4) begin
         lead_count = 2'd3;
         lead_hi    = 8'h8F;
      end else begin
         lead_ok = 1'b0;
      end
   end

   always_comb begin
      push_entry.data_byte  = in_byte;
      push_entry.last_byte  = in_last;
      push_entry.position   = pos_ff;
      push_entry.lead_ok    = lead_ok;
      push_entry.lead_count = lead_count;
      push_entry.lead_lo    = lead_lo;
      push_entry.lead_hi    = lead_hi;
   end

   // saturating offset, back to zero after the last byte of a file
   always_comb begin
      pos_in = pos_ff;
      if (accept) begin
         if (in_last) begin
            pos_in = '0;
         end else if (pos_ff != {POSITION_BITS{1'b1}}) begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule

>>> hdl/utv_queue.sv
// short fifo of classified requests between front and back
module utv_queue
   import utv_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  entry_type in_entry,
   output logic      out_valid,
   input  logic      out_ready,
   output entry_type out_entry
);

   entry_type            mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_BITS-1:0] count_ff, count_in;
   logic                 push, pop;

   assign in_ready  = count_ff != QCNT_BITS'(QUEUE_DEPTH);
   assign out_valid = count_ff != '0;
   assign out_entry = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

endmodule

>>> hdl/utv_back.sv
// back end: sequence checking, failure tracking and verdict register
module utv_back
   import utv_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic [LIMIT_BITS-1:0]  scan_limit,
   input  logic                   pop_valid,
   output logic                   pop_ready,
   input  entry_type              pop_entry,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic                   out_text_ok,
   output logic [OFFSET_BITS-1:0] out_bad_offset
);

   logic [1:0]               cont_ff, cont_in;
   logic [7:0]               lo_ff, lo_in, hi_ff, hi_in;
   logic [POSITION_BITS-1:0] start_ff, start_in;
   logic                     fail_ff, fail_in;
   logic [POSITION_BITS-1:0] failpos_ff, failpos_in;
   logic                     valid_ff, valid_in;
   logic                     ok_ff, ok_in;
   logic [OFFSET_BITS-1:0]   offset_ff, offset_in;
   logic                     pop;
   logic [POSITION_BITS:0]   file_len;
   logic                     too_short, counted;

   assign pop_ready      = !pop_entry.last_byte || !valid_ff || out_ready;
   assign pop            = pop_valid && pop_ready;
   assign out_valid      = valid_ff;
   assign out_text_ok    = ok_ff;
   assign out_bad_offset = offset_ff;

   // sequence state after this byte
   always_comb begin
      cont_in    = cont_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      start_in   = start_ff;
      fail_in    = fail_ff;
      failpos_in = failpos_ff;
      if (!fail_ff) begin
         if (cont_ff != 2'd0) begin
            if (pop_entry.data_byte < lo_ff || pop_entry.data_byte > hi_ff) begin
               fail_in    = 1'b1;
               failpos_in = start_ff;
               cont_in    = 2'd0;
            end else begin
               cont_in = cont_ff - 1'b1;
               lo_in   = CONT_LO;
               hi_in   = CONT_HI;
            end
         end else if ({{LIMIT_BITS{1'b0}}, pop_entry.position}
                      < {{POSITION_BITS{1'b0}}, scan_limit}) begin
            start_in = pop_entry.position;
            if (!pop_entry.lead_ok) begin
               fail_in    = 1'b1;
               failpos_in = pop_entry.position;
            end else begin
               cont_in = pop_entry.lead_count;
               lo_in   = pop_entry.lead_lo;
               hi_in   = pop_entry.lead_hi;
            end
         end
      end
   end

   // verdict on the last byte
   always_comb begin
      file_len  = {1'b0, pop_entry.position} + 1'b1;
      too_short = file_len < MIN_FILE_LEN;
      counted   = fail_in && (({1'b0, failpos_in} + TAIL_GAP) < file_len);
      valid_in  = valid_ff && !out_ready;
      ok_in     = ok_ff;
      offset_in = offset_ff;
      if (pop && pop_entry.last_byte) begin
         valid_in  = 1'b1;
         ok_in     = !too_short && !counted;
         offset_in = (!too_short && counted) ? OFFSET_BITS'(failpos_in) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cont_ff    <= 2'd0;
         lo_ff      <= CONT_LO;
         hi_ff      <= CONT_HI;
         start_ff   <= '0;
         fail_ff    <= 1'b0;
         failpos_ff <= '0;
         valid_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (pop) begin
            if (pop_entry.last_byte) begin
               cont_ff    <= 2'd0;
               lo_ff      <= CONT_LO;
               hi_ff      <= CONT_HI;
               start_ff   <= '0;
               fail_ff    <= 1'b0;
               failpos_ff <= '0;
            end else begin
               cont_ff    <= cont_in;
               lo_ff      <= lo_in;
               hi_ff      <= hi_in;
               start_ff   <= start_in;
               fail_ff    <= fail_in;
               failpos_ff <= failpos_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      ok_ff     <= ok_in;
      offset_ff <= offset_in;
   end

endmodule

>>> hdl/utf8_text_validator.sv
// top level of the streaming utf-8 text validator
// an accepted last byte passes through the queue to the back end, which registers its verdict on rsp
// throughput: one byte per cycle unless stalled; the back end retires one queued byte a cycle
// a waiting verdict stalls the back end only on the next file's last byte
// reset (synchronous): clears offset, sequence state, queue and output valid
// scan_limit returns to 1000 on reset and keeps its value across files
module utf8_text_validator
   import utv_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   // request channel
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [7:0]               req_tdata,   // [7:0] data_byte
   input  logic                     req_tlast,   // last_byte
   // verdict channel
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [15:0]              rsp_tdata,   // [15:0] bad_offset
   output logic                     rsp_tuser,   // text_ok
   // register port
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   logic [LIMIT_BITS-1:0]  scan_limit_ff, scan_limit_in;
   logic                   csr_write;

   // front to queue
   logic                   push_valid, push_ready;
   entry_type              push_entry;
   // queue to back
   logic                   pop_valid, pop_ready;
   entry_type              pop_entry;
   logic [OFFSET_BITS-1:0] bad_offset;

   // ---------------- register port ----------------
   // word address selects the register, the low byte-address bits are ignored
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      scan_limit_in = scan_limit_ff;
      if (csr_write && csr_paddr[CSR_ADDR_BITS-1] == REG_SCAN_LIMIT) begin
         scan_limit_in = csr_pwdata[LIMIT_BITS-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[CSR_ADDR_BITS-1] == REG_SCAN_LIMIT) begin
         csr_prdata = CSR_DATA_BITS'(scan_limit_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_limit_ff <= SCAN_LIMIT_RESET;
      end else begin
         scan_limit_ff <= scan_limit_in;
      end
   end

   // ---------------- front: offset and lead classification ----------------
   utv_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_byte    (req_tdata),
      .in_last    (req_tlast),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   // ---------------- queue: lets front and back stall apart ----------------
   utv_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_entry  (push_entry),
      .out_valid (pop_valid),
      .out_ready (pop_ready),
      .out_entry (pop_entry)
   );

   // ---------------- back: sequence check and verdict ----------------
   utv_back u_back (
      .clock          (clock),
      .reset          (reset),
      .scan_limit     (scan_limit_ff),
      .pop_valid      (pop_valid),
      .pop_ready      (pop_ready),
      .pop_entry      (pop_entry),
      .out_valid      (rsp_tvalid),
      .out_ready      (rsp_tready),
      .out_text_ok    (rsp_tuser),
      .out_bad_offset (bad_offset)
   );

   assign rsp_tdata = 16'(bad_offset);

   // ---------------- assertions ----------------
   // a new verdict only follows the retirement of a last byte
   a_verdict_from_last : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(pop_valid && pop_ready && pop_entry.last_byte))
      else $error("verdict without a retired last byte");

   // a passing file reports offset zero
   a_ok_offset_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("passing verdict with nonzero offset");

   // a last byte is held back while an untaken verdict occupies the output
   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready && pop_valid && pop_entry.last_byte |-> !pop_ready)
      else $error("verdict register overwritten");

endmodule
